### sv/rttm_pkg.sv
// Shared types, codes and sizes for the rule table trigger matcher.
// Used by rttm_rule_eval and rule_table_trigger_matcher; depends on nothing.

package rttm_pkg;

    // Table and result sizes
    localparam int RULES       = 20;
    localparam int MAX_RESULTS = 20;
    localparam int IDX_W       = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CNT_W       = $clog2(RULES + 1);
    localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

    // Fixed field widths
    localparam int VAL_W  = 32;
    localparam int READ_N = 4;
    localparam int SLOT_W = 5;
    localparam int TASK_W = 8;

    // Request opcodes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_EVAL   = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd2;
    localparam logic [1:0] STAT_BAD_KIND  = 2'd3;

    // Sensor kinds
    localparam logic [2:0] KIND_TIME    = 3'd0;
    localparam logic [2:0] KIND_ENERGY  = 3'd1;
    localparam logic [2:0] KIND_CURRENT = 3'd4;

    // Compare modes
    localparam logic [1:0] MODE_EQ      = 2'd0;
    localparam logic [1:0] MODE_LT      = 2'd1;
    localparam logic [1:0] MODE_GT      = 2'd2;
    localparam logic [1:0] MODE_BETWEEN = 2'd3;

    // Calendar and clock fields
    typedef struct packed {
        logic [3:0] month;
        logic [4:0] month_day;
        logic [2:0] week_day;
        logic [4:0] hour;
        logic [5:0] minute;
    } now_t;

    // One table entry
    typedef struct packed {
        logic [2:0]        kind;
        logic [1:0]        mode;
        now_t              sched;
        logic [TASK_W-1:0] task_num;
        logic [VAL_W-1:0]  low;
        logic [VAL_W-1:0]  high;
    } rule_t;

    // Latched sensor readings: energy, power, voltage, current
    typedef logic [READ_N-1:0][VAL_W-1:0] readings_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EVAL
    } state_t;

endpackage

### sv/rule_table_trigger_matcher.sv
// Rule table trigger matcher: compacted rule table, sensor readings and match walk.
// Depends on rttm_pkg and rttm_rule_eval.
// Add, update, bad remove: result in the cycle after acceptance, next request in that cycle.
// Remove: each later entry moves down one slot before the result; evaluate: the table is walked
// with a result per match, the last flagged, or one no-match result; one entry per cycle, next
// request at the final result's edge. Receiver cannot stall; reset clears count, readings.

module rule_table_trigger_matcher
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 op,
    input  logic [2:0]                 sensor_kind,
    input  logic [1:0]                 compare_mode,
    input  logic [3:0]                 month,
    input  logic [4:0]                 month_day,
    input  logic [2:0]                 week_day,
    input  logic [4:0]                 hour,
    input  logic [5:0]                 minute,
    input  logic signed [31:0]         value_a,
    input  logic signed [31:0]         value_b,
    input  logic [7:0]                 task_or_slot,
    output logic                       done,
    output logic [1:0]                 status,
    output logic                       matched,
    output logic [7:0]                 task_number,
    output logic [4:0]                 rule_slot,
    output logic                       last
);

    localparam int IDX_W   = rttm_pkg::IDX_W;
    localparam int CNT_W   = rttm_pkg::CNT_W;
    localparam int FOUND_W = rttm_pkg::FOUND_W;
    localparam int SLOT_W  = rttm_pkg::SLOT_W;
    localparam int TASK_W  = rttm_pkg::TASK_W;

    rttm_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [FOUND_W-1:0]  found_reg, found_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    rttm_pkg::rule_t     rd_data_reg;
    rttm_pkg::now_t      now_reg, now_next;
    logic [IDX_W-1:0]    rem_slot_reg, rem_slot_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [TASK_W-1:0]   pend_task_reg, pend_task_next;
    logic [IDX_W-1:0]    pend_slot_reg, pend_slot_next;
    rttm_pkg::readings_t readings_reg, readings_next;

    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic                matched_reg, matched_next;
    logic [TASK_W-1:0]   task_number_reg, task_number_next;
    logic [SLOT_W-1:0]   rule_slot_reg, rule_slot_next;
    logic                last_reg, last_next;

    rttm_pkg::rule_t     rule_mem [rttm_pkg::RULES];
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    rttm_pkg::rule_t     mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;

    logic                accept;
    logic                remove_ok;
    logic                walk_more;
    logic                eval_issue;
    logic                hit;
    logic [2:0]          kind_m1;
    rttm_pkg::rule_t     new_rule;

    assign busy      = (state_reg != rttm_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign remove_ok = (task_or_slot < TASK_W'(count_reg));
    assign walk_more = (ptr_reg < count_reg);
    assign eval_issue = walk_more && (found_reg < FOUND_W'(rttm_pkg::MAX_RESULTS));
    assign kind_m1   = sensor_kind - 3'd1;

    // Assemble the entry of an add request
    always_comb
    begin
        new_rule.kind            = sensor_kind;
        new_rule.mode            = compare_mode;
        new_rule.sched.month     = month;
        new_rule.sched.month_day = month_day;
        new_rule.sched.week_day  = week_day;
        new_rule.sched.hour      = hour;
        new_rule.sched.minute    = minute;
        new_rule.task_num        = task_or_slot;
        new_rule.low             = value_a;
        new_rule.high            = value_b;
    end

    // Shared compare unit on the entry just read
    rttm_rule_eval u_rule_eval
    (
        .rule     (rd_data_reg),
        .now      (now_reg),
        .readings (readings_reg),
        .match    (hit)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rttm_pkg::ST_IDLE:
            begin
                if (accept && (op == rttm_pkg::OP_REMOVE) && remove_ok)
                    state_next = rttm_pkg::ST_SHIFT;
                else if (accept && (op == rttm_pkg::OP_EVAL))
                    state_next = rttm_pkg::ST_EVAL;
            end
            rttm_pkg::ST_SHIFT:
            begin
                if (!walk_more && !rd_valid_reg)
                    state_next = rttm_pkg::ST_IDLE;
            end
            rttm_pkg::ST_EVAL:
            begin
                if (!eval_issue && !rd_valid_reg)
                    state_next = rttm_pkg::ST_IDLE;
            end
            default:
                state_next = rttm_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory control and results
    always_comb
    begin
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        found_next       = found_reg;
        rd_valid_next    = 1'b0;
        rd_idx_next      = rd_idx_reg;
        now_next         = now_reg;
        rem_slot_next    = rem_slot_reg;
        pend_valid_next  = pend_valid_reg;
        pend_task_next   = pend_task_reg;
        pend_slot_next   = pend_slot_reg;
        readings_next    = readings_reg;
        done_next        = 1'b0;
        status_next      = rttm_pkg::STAT_OK;
        matched_next     = 1'b0;
        task_number_next = '0;
        rule_slot_next   = '0;
        last_next        = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = new_rule;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        unique case (state_reg)
            rttm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        rttm_pkg::OP_ADD:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            if (count_reg >= CNT_W'(rttm_pkg::RULES))
                                status_next = rttm_pkg::STAT_FULL;
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = count_reg[IDX_W-1:0];
                                rule_slot_next = SLOT_W'(count_reg);
                                count_next     = count_reg + CNT_W'(1);
                            end
                        end
                        rttm_pkg::OP_REMOVE:
                        begin
                            if (remove_ok)
                            begin
                                rem_slot_next = IDX_W'(task_or_slot);
                                ptr_next      = CNT_W'(task_or_slot) + CNT_W'(1);
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                last_next   = 1'b1;
                                status_next = rttm_pkg::STAT_BAD_INDEX;
                            end
                        end
                        rttm_pkg::OP_UPDATE:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            if ((sensor_kind >= rttm_pkg::KIND_ENERGY) &&
                                (sensor_kind <= rttm_pkg::KIND_CURRENT))
                                readings_next[kind_m1[1:0]] = value_a;
                            else
                                status_next = rttm_pkg::STAT_BAD_KIND;
                        end
                        rttm_pkg::OP_EVAL:
                        begin
                            now_next.month     = month;
                            now_next.month_day = month_day;
                            now_next.week_day  = week_day;
                            now_next.hour      = hour;
                            now_next.minute    = minute;
                            ptr_next           = '0;
                            found_next         = '0;
                            pend_valid_next    = 1'b0;
                        end
                    endcase
                end
            end

            rttm_pkg::ST_SHIFT:
            begin
                // Write the entry read last cycle one slot down
                if (rd_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_reg - IDX_W'(1);
                    mem_wdata = rd_data_reg;
                end
                // Read the next entry, or finish once drained
                if (walk_more)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = ptr_reg[IDX_W-1:0];
                    rd_valid_next = 1'b1;
                    rd_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                else if (!rd_valid_reg)
                begin
                    done_next      = 1'b1;
                    last_next      = 1'b1;
                    rule_slot_next = SLOT_W'(rem_slot_reg);
                    count_next     = count_reg - CNT_W'(1);
                end
            end

            rttm_pkg::ST_EVAL:
            begin
                // Advance the read pointer
                if (eval_issue)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = ptr_reg[IDX_W-1:0];
                    rd_valid_next = 1'b1;
                    rd_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                // Hold each match until the next one shows it is not the last
                if (rd_valid_reg && hit &&
                    (found_reg < FOUND_W'(rttm_pkg::MAX_RESULTS)))
                begin
                    if (pend_valid_reg)
                    begin
                        done_next        = 1'b1;
                        matched_next     = 1'b1;
                        task_number_next = pend_task_reg;
                        rule_slot_next   = SLOT_W'(pend_slot_reg);
                    end
                    pend_valid_next = 1'b1;
                    pend_task_next  = rd_data_reg.task_num;
                    pend_slot_next  = rd_idx_reg;
                    found_next      = found_reg + FOUND_W'(1);
                end
                // Drop the held match, or a no-match result, as the last one
                if (!eval_issue && !rd_valid_reg)
                begin
                    done_next = 1'b1;
                    last_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        matched_next     = 1'b1;
                        task_number_next = pend_task_reg;
                        rule_slot_next   = SLOT_W'(pend_slot_reg);
                    end
                end
            end

            default:
            begin
            end
        endcase
    end

    // Rule memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            rule_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= rule_mem[mem_raddr];
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rttm_pkg::ST_IDLE;
            count_reg       <= '0;
            ptr_reg         <= '0;
            found_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            now_reg         <= '0;
            rem_slot_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            pend_task_reg   <= '0;
            pend_slot_reg   <= '0;
            readings_reg    <= '0;
            done_reg        <= 1'b0;
            status_reg      <= rttm_pkg::STAT_OK;
            matched_reg     <= 1'b0;
            task_number_reg <= '0;
            rule_slot_reg   <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            ptr_reg         <= ptr_next;
            found_reg       <= found_next;
            rd_valid_reg    <= rd_valid_next;
            rd_idx_reg      <= rd_idx_next;
            now_reg         <= now_next;
            rem_slot_reg    <= rem_slot_next;
            pend_valid_reg  <= pend_valid_next;
            pend_task_reg   <= pend_task_next;
            pend_slot_reg   <= pend_slot_next;
            readings_reg    <= readings_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            matched_reg     <= matched_next;
            task_number_reg <= task_number_next;
            rule_slot_reg   <= rule_slot_next;
            last_reg        <= last_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign matched     = matched_reg;
    assign task_number = task_number_reg;
    assign rule_slot   = rule_slot_reg;
    assign last        = last_reg;

    // The table never holds more than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(rttm_pkg::RULES))
        else $error("rule count above table capacity");

    // Add and update answer in the next cycle with a final result
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((op == rttm_pkg::OP_ADD) || (op == rttm_pkg::OP_UPDATE)))
        |=> (done && last))
        else $error("add or update gave no result");

    // No table read stays in flight once the walk is over
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rttm_pkg::ST_IDLE) |-> !rd_valid_reg)
        else $error("read in flight while idle");

    // A non-final result is always followed by more of the same evaluate
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> (state_reg == rttm_pkg::ST_EVAL))
        else $error("non-final result outside an evaluate");

    // Matches only come with status ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && matched) |-> (status == rttm_pkg::STAT_OK))
        else $error("match reported with error status");

endmodule

### sv/rttm_rule_eval.sv
// Rule compare unit: decides whether one table entry fires for the current
// clock fields and sensor readings. Depends on rttm_pkg.

module rttm_rule_eval
(
    input  rttm_pkg::rule_t     rule,
    input  rttm_pkg::now_t      now,
    input  rttm_pkg::readings_t readings,
    output logic                match
);

    logic [2:0]                       kind_m1;
    logic signed [rttm_pkg::VAL_W-1:0] reading;
    logic signed [rttm_pkg::VAL_W-1:0] low;
    logic signed [rttm_pkg::VAL_W-1:0] high;
    logic                             time_hit;
    logic                             sensor_hit;

    // Select the reading and compare against the thresholds
    always_comb
    begin
        kind_m1 = rule.kind - 3'd1;
        reading = $signed(readings[kind_m1[1:0]]);
        low     = $signed(rule.low);
        high    = $signed(rule.high);
        unique case (rule.mode)
            rttm_pkg::MODE_EQ:      sensor_hit = (reading == low);
            rttm_pkg::MODE_LT:      sensor_hit = (reading < low);
            rttm_pkg::MODE_GT:      sensor_hit = (reading > low);
            rttm_pkg::MODE_BETWEEN: sensor_hit = (reading > low) && (reading < high);
        endcase
    end

    // Match the schedule; a zero month, day or weekday matches any
    always_comb
    begin
        time_hit = ((rule.sched.month == 4'd0) || (rule.sched.month == now.month)) &&
                   ((rule.sched.month_day == 5'd0) ||
                    (rule.sched.month_day == now.month_day)) &&
                   ((rule.sched.week_day == 3'd0) ||
                    (rule.sched.week_day == now.week_day)) &&
                   (rule.sched.hour == now.hour) &&
                   (rule.sched.minute == now.minute);
    end

    // Pick by kind; invalid kinds never fire
    always_comb
    begin
        priority if (rule.kind == rttm_pkg::KIND_TIME)
            match = time_hit;
        else if (rule.kind <= rttm_pkg::KIND_CURRENT)
            match = sensor_hit;
        else
            match = 1'b0;
    end

endmodule

### bench/tb_top.sv
// Self-checking bench for rule_table_trigger_matcher: directed and random requests
// against a predictor of the rule table, readings and match walk held in a scoreboard class.
// Depends on rttm_pkg and the rule_table_trigger_matcher RTL.
`timescale 1ns / 1ps

module tb_top;

    // Kinds and limits not named in the package
    localparam logic [2:0] KIND_POWER   = 3'd2;
    localparam logic [2:0] KIND_VOLTAGE = 3'd3;
    localparam logic [2:0] KIND_INVALID = 3'd7;
    localparam int RANDOM_ITEMS   = 300;
    localparam int END_WAIT       = rttm_pkg::RULES + 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;

    // One request as it stands on the input ports
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  kind;
        logic [1:0]  mode;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [31:0] val_a;
        logic [31:0] val_b;
        logic [7:0]  arg;
    } request_t;

    // One result as it stands on the output ports
    typedef struct packed {
        logic [1:0] status;
        logic       hit;
        logic [7:0] task_num;
        logic [4:0] slot;
        logic       last_flag;
    } response_t;

    // Rule table predictor and queue of pending responses
    class trigger_scoreboard;
        request_t    rules[rttm_pkg::RULES];
        int          rule_count;
        logic [31:0] readings[rttm_pkg::READ_N];
        response_t   pending[$];
        int          errors;

        function new();
            rule_count = 0;
            errors = 0;
            foreach (readings[i])
                readings[i] = '0;
        endfunction

        function void push_reply(logic [1:0] st, logic h, logic [7:0] tk, logic [4:0] sl,
                                 logic lf);
            response_t r;
            r.status = st;
            r.hit = h;
            r.task_num = tk;
            r.slot = sl;
            r.last_flag = lf;
            pending.push_back(r);
        endfunction

        // Decide whether one stored rule fires for the given clock fields
        function bit rule_fires(request_t r, request_t now);
            logic signed [31:0] rd;
            logic signed [31:0] lo;
            logic signed [31:0] hi;
            if (r.kind == rttm_pkg::KIND_TIME)
                return (r.month == 0 || r.month == now.month) &&
                       (r.mday == 0 || r.mday == now.mday) &&
                       (r.wday == 0 || r.wday == now.wday) &&
                       r.hour == now.hour && r.minute == now.minute;
            if (r.kind > rttm_pkg::KIND_CURRENT)
                return 1'b0;
            rd = readings[r.kind - rttm_pkg::KIND_ENERGY];
            lo = r.val_a;
            hi = r.val_b;
            case (r.mode)
                rttm_pkg::MODE_EQ: return rd == lo;
                rttm_pkg::MODE_LT: return rd < lo;
                rttm_pkg::MODE_GT: return rd > lo;
                default: return rd > lo && rd < hi;
            endcase
        endfunction

        // Apply an accepted request and queue the responses it causes
        function void note_request(request_t q);
            int i;
            int found;
            case (q.op)
                rttm_pkg::OP_ADD:
                    if (rule_count >= rttm_pkg::RULES)
                        push_reply(rttm_pkg::STAT_FULL, 1'b0, '0, '0, 1'b1);
                    else
                    begin
                        rules[rule_count] = q;
                        push_reply(rttm_pkg::STAT_OK, 1'b0, '0,
                                   rttm_pkg::SLOT_W'(rule_count), 1'b1);
                        rule_count++;
                    end
                rttm_pkg::OP_REMOVE:
                    if (int'(q.arg) >= rule_count)
                        push_reply(rttm_pkg::STAT_BAD_INDEX, 1'b0, '0, '0, 1'b1);
                    else
                    begin
                        for (i = int'(q.arg); i + 1 < rule_count; i++)
                            rules[i] = rules[i + 1];
                        rule_count--;
                        push_reply(rttm_pkg::STAT_OK, 1'b0, '0,
                                   q.arg[rttm_pkg::SLOT_W-1:0], 1'b1);
                    end
                rttm_pkg::OP_UPDATE:
                    if (q.kind >= rttm_pkg::KIND_ENERGY && q.kind <= rttm_pkg::KIND_CURRENT)
                    begin
                        readings[q.kind - rttm_pkg::KIND_ENERGY] = q.val_a;
                        push_reply(rttm_pkg::STAT_OK, 1'b0, '0, '0, 1'b1);
                    end
                    else
                        push_reply(rttm_pkg::STAT_BAD_KIND, 1'b0, '0, '0, 1'b1);
                default:
                begin
                    found = 0;
                    for (i = 0; i < rule_count && found < rttm_pkg::MAX_RESULTS; i++)
                        if (rule_fires(rules[i], q))
                        begin
                            push_reply(rttm_pkg::STAT_OK, 1'b1, rules[i].arg,
                                       rttm_pkg::SLOT_W'(i), 1'b0);
                            found++;
                        end
                    if (found == 0)
                        push_reply(rttm_pkg::STAT_OK, 1'b0, '0, '0, 1'b1);
                    else
                        pending[pending.size() - 1].last_flag = 1'b1;
                end
            endcase
        endfunction

        // Compare one strobed result against the oldest pending response
        function void check_result(response_t got);
            response_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected result st %0d m %0d task %0d slot %0d last %0d",
                             $realtime, got.status, got.hit, got.task_num, got.slot,
                             got.last_flag);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.hit !== want.hit ||
                got.task_num !== want.task_num || got.slot !== want.slot ||
                got.last_flag !== want.last_flag)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"%0t: mismatch exp st %0d m %0d task %0d slot %0d last %0d,",
                              " got st %0d m %0d task %0d slot %0d last %0d"},
                             $realtime, want.status, want.hit, want.task_num, want.slot,
                             want.last_flag, got.status, got.hit, got.task_num, got.slot,
                             got.last_flag);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         op = rttm_pkg::OP_ADD;
    logic [2:0]         sensor_kind = rttm_pkg::KIND_TIME;
    logic [1:0]         compare_mode = rttm_pkg::MODE_EQ;
    logic [3:0]         month = '0;
    logic [4:0]         month_day = '0;
    logic [2:0]         week_day = '0;
    logic [4:0]         hour = '0;
    logic [5:0]         minute = '0;
    logic signed [31:0] value_a = '0;
    logic signed [31:0] value_b = '0;
    logic [7:0]         task_or_slot = '0;
    logic               done;
    logic [1:0]         status;
    logic               matched;
    logic [7:0]         task_number;
    logic [4:0]         rule_slot;
    logic               last;

    trigger_scoreboard sb;
    int stall_cycles = 0;
    int n;

    rule_table_trigger_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .sensor_kind  (sensor_kind),
        .compare_mode (compare_mode),
        .month        (month),
        .month_day    (month_day),
        .week_day     (week_day),
        .hour         (hour),
        .minute       (minute),
        .value_a      (value_a),
        .value_b      (value_b),
        .task_or_slot (task_or_slot),
        .done         (done),
        .status       (status),
        .matched      (matched),
        .task_number  (task_number),
        .rule_slot    (rule_slot),
        .last         (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // Check strobed results, then note the request accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (done)
                sb.check_result('{status, matched, task_number, rule_slot, last});
            if (start && !busy)
                sb.note_request('{op, sensor_kind, compare_mode, month, month_day, week_day,
                                  hour, minute, value_a, value_b, task_or_slot});
        end
    end

    // Abort when neither side moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Request builders
    function automatic request_t time_rule(logic [3:0] mo, logic [4:0] md, logic [2:0] wd,
                                           logic [4:0] hr, logic [5:0] mi, logic [7:0] tk);
        request_t r;
        r = '0;
        r.op = rttm_pkg::OP_ADD;
        r.kind = rttm_pkg::KIND_TIME;
        r.month = mo;
        r.mday = md;
        r.wday = wd;
        r.hour = hr;
        r.minute = mi;
        r.arg = tk;
        return r;
    endfunction

    function automatic request_t sensor_rule(logic [2:0] kd, logic [1:0] md, logic [31:0] a,
                                             logic [31:0] b, logic [7:0] tk);
        request_t r;
        r = '0;
        r.op = rttm_pkg::OP_ADD;
        r.kind = kd;
        r.mode = md;
        r.val_a = a;
        r.val_b = b;
        r.arg = tk;
        return r;
    endfunction

    function automatic request_t update_req(logic [2:0] kd, logic [31:0] v);
        request_t r;
        r = '0;
        r.op = rttm_pkg::OP_UPDATE;
        r.kind = kd;
        r.val_a = v;
        return r;
    endfunction

    function automatic request_t remove_req(logic [7:0] sl);
        request_t r;
        r = '0;
        r.op = rttm_pkg::OP_REMOVE;
        r.arg = sl;
        return r;
    endfunction

    function automatic request_t eval_req(logic [3:0] mo, logic [4:0] md, logic [2:0] wd,
                                          logic [4:0] hr, logic [5:0] mi);
        request_t r;
        r = time_rule(mo, md, wd, hr, mi, '0);
        r.op = rttm_pkg::OP_EVAL;
        return r;
    endfunction

    // Pick a favored value most of the time so rules and clocks line up
    function automatic int near(int hi, int p0, int p1, int p2);
        case ($urandom_range(3))
            0: return p0;
            1: return p1;
            2: return p2;
            default: return $urandom_range(hi);
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0;
            3: return 32'h1;
            4: return 32'h7FFF_FFFF;
            5: return 32'd100;
            default: return $urandom;
        endcase
    endfunction

    // Build a random request; filling favors adds, draining favors removes
    function automatic request_t make_random(bit filling);
        request_t r;
        int pick;
        int add_w;
        int rem_w;
        pick = $urandom_range(99);
        add_w = filling ? 40 : 20;
        rem_w = filling ? 10 : 30;
        r.op = rttm_pkg::OP_EVAL;
        r.kind = rttm_pkg::KIND_TIME;
        r.mode = 2'($urandom_range(3));
        r.month = 4'(near(12, 0, 1, 12));
        r.mday = 5'(near(31, 0, 1, 31));
        r.wday = 3'(near(6, 0, 3, 6));
        r.hour = 5'(near(23, 0, 5, 23));
        r.minute = 6'(near(59, 0, 5, 59));
        r.val_a = rand_value();
        r.val_b = rand_value();
        r.arg = 8'($urandom_range(255));
        if (pick < 5)
        begin
            // noise: any operation with unrelated fields
            r.op = 2'($urandom_range(3));
            r.kind = 3'($urandom_range(7));
            r.val_a = $urandom;
            r.val_b = $urandom;
        end
        else if (pick < 5 + add_w)
        begin
            r.op = rttm_pkg::OP_ADD;
            case ($urandom_range(9))
                0, 1, 2, 3: r.kind = rttm_pkg::KIND_TIME;
                9: r.kind = 3'($urandom_range(5, 7));
                default: r.kind = 3'($urandom_range(1, 4));
            endcase
        end
        else if (pick < 5 + add_w + rem_w)
        begin
            r.op = rttm_pkg::OP_REMOVE;
            if (sb.rule_count > 0 && $urandom_range(4) != 0)
                r.arg = 8'($urandom_range(sb.rule_count - 1));
        end
        else if (pick < 25 + add_w + rem_w)
        begin
            r.op = rttm_pkg::OP_UPDATE;
            r.kind = ($urandom_range(7) == 0) ? 3'($urandom_range(7))
                                              : 3'($urandom_range(1, 4));
        end
        return r;
    endfunction

    // Drive one request from a falling edge and hold it until accepted
    task automatic send(request_t r);
        op <= r.op;
        sensor_kind <= r.kind;
        compare_mode <= r.mode;
        month <= r.month;
        month_day <= r.mday;
        week_day <= r.wday;
        hour <= r.hour;
        minute <= r.minute;
        value_a <= r.val_a;
        value_b <= r.val_b;
        task_or_slot <= r.arg;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_cycles(int cnt);
        repeat (cnt)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Hold off new requests until every pending response has come back
    task automatic pause_until_drained();
        while (sb.pending.size() != 0)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table, bad kinds and reading extremes
        send(eval_req(0, 0, 0, 0, 0));
        send(remove_req(8'd0));
        send(update_req(rttm_pkg::KIND_TIME, 32'd5));
        send(update_req(KIND_INVALID, 32'hFFFF_FFFF));
        send(update_req(rttm_pkg::KIND_ENERGY, 32'h7FFF_FFFF));
        send(update_req(KIND_POWER, 32'h8000_0000));
        send(update_req(KIND_VOLTAGE, 32'h0));
        send(update_req(rttm_pkg::KIND_CURRENT, 32'hFFFF_FFFF));

        // Rules for every compare mode, wildcard and exact time rules, an invalid kind
        send(time_rule(0, 0, 0, 23, 59, 8'd0));
        send(time_rule(12, 31, 6, 0, 0, 8'd255));
        send(sensor_rule(rttm_pkg::KIND_ENERGY, rttm_pkg::MODE_EQ, 32'h7FFF_FFFF, 32'h0,
                         8'd1));
        send(sensor_rule(KIND_POWER, rttm_pkg::MODE_LT, 32'h8000_0000, 32'h0, 8'd2));
        send(sensor_rule(KIND_VOLTAGE, rttm_pkg::MODE_GT, 32'hFFFF_FFFF, 32'h0, 8'd3));
        send(sensor_rule(rttm_pkg::KIND_CURRENT, rttm_pkg::MODE_BETWEEN, 32'hFFFF_FFFE,
                         32'h0, 8'd4));
        send(sensor_rule(rttm_pkg::KIND_CURRENT, rttm_pkg::MODE_BETWEEN, 32'h0,
                         32'hFFFF_FFFE, 8'd5));
        send(sensor_rule(KIND_INVALID, rttm_pkg::MODE_EQ, 32'h0, 32'h0, 8'd6));
        send(sensor_rule(KIND_POWER, rttm_pkg::MODE_LT, 32'h7FFF_FFFF, 32'h0, 8'd7));
        send(eval_req(12, 31, 6, 0, 0));
        send(eval_req(3, 4, 2, 23, 59));
        send(eval_req(11, 31, 6, 0, 0));

        // Shift from the front, drop the tail, then out-of-range slots
        send(remove_req(8'd0));
        send(remove_req(8'(sb.rule_count - 1)));
        send(remove_req(8'(sb.rule_count)));
        send(remove_req(8'd255));
        send(eval_req(12, 31, 6, 0, 0));
        pause_until_drained();

        // Empty the table, fill it with rules that all fire, overflow it
        while (sb.rule_count > 0)
            send(remove_req(8'($urandom_range(sb.rule_count - 1))));
        repeat (rttm_pkg::RULES)
            send(time_rule(0, 0, 0, 5, 5, 8'($urandom_range(255))));
        send(time_rule(0, 0, 0, 5, 5, 8'd9));
        send(eval_req(4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
                      3'($urandom_range(6)), 5, 5));
        send(eval_req(0, 0, 0, 5, 6));

        // Random traffic, alternating fill and drain, with one stretch free of idle gaps
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ((n < 120 || n >= 200) && $urandom_range(99) < 29)
                idle_cycles($urandom_range(1, 3));
            if (n == 250)
                pause_until_drained();
            send(make_random((n / 60) % 2 == 0));
        end

        // Drain and allow for stray results
        idle_cycles(1);
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (END_WAIT)
            @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
